// ===== rtl/core/ssmb_pkg.sv =====
// ============================================================================
// ssmb_pkg
// Types and constants shared by the spaced site max bonus block.
// ============================================================================
package ssmb_pkg;

    localparam int unsigned LOC_W   = 16;
    localparam int unsigned BONUS_W = 16;
    localparam int unsigned BEST_W  = 26;
    localparam int unsigned IDX_W   = 11;
    localparam logic [15:0] GAP_RESET = 16'd5;
    localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

    typedef logic [LOC_W-1:0]   t_loc;
    typedef logic [BONUS_W-1:0] t_bonus;
    typedef logic [BEST_W-1:0]  t_best;
    typedef logic [IDX_W-1:0]   t_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_ADD,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/ssmb_store.sv =====
// ============================================================================
// ssmb_store
// Site store: location and best total per stored site, one write and one
// registered read per cycle.
// ============================================================================
module ssmb_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  ssmb_pkg::t_loc        i_wloc,
    input  ssmb_pkg::t_best       i_wbest,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output ssmb_pkg::t_loc        o_rloc,
    output ssmb_pkg::t_best       o_rbest
);

    ssmb_pkg::t_loc  r_loc_mem  [DEPTH];
    ssmb_pkg::t_best r_best_mem [DEPTH];
    ssmb_pkg::t_loc  r_rloc;
    ssmb_pkg::t_best r_rbest;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_loc_mem[i_waddr]  <= i_wloc;
            r_best_mem[i_waddr] <= i_wbest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rloc  <= r_loc_mem[i_raddr];
            r_rbest <= r_best_mem[i_raddr];
        end
    end

    assign o_rloc  = r_rloc;
    assign o_rbest = r_rbest;

endmodule

// ===== rtl/core/spaced_site_max_bonus.sv =====
// ============================================================================
// spaced_site_max_bonus
// Best total bonus over sites along a line with a minimum spacing, one site
// at a time, with a backward scan over the stored sites of the run.
// ============================================================================
// Input channel i_valid/o_ready carries one site (location, bonus, last).
// Output channel o_valid/i_ready returns one result per site: best total,
// 1-based site index, predecessor index (0 for none), overflow and last.
// Write i_min_gap with i_min_gap_we while no transaction is in flight.
// Each site scans the stored entries backward: every visited entry is read
// (S_READ) and then compared (S_CMP) on the single read port of the site
// store, then S_ADD forms the total and S_DONE loads the result. The first
// site of a run skips the scan; a site beyond capacity goes straight to S_DONE.
// The block takes one site at a time; o_ready rises again as the result is
// loaded, so the next site can enter while the result waits.
// A stalled receiver holds the result; a finished site then waits in the
// final state until the output register frees.
// Reset clears the run (no sites stored) and sets min_gap to 5. A site with
// last set clears the run after its result. Store contents need no clearing.
// ============================================================================
module spaced_site_max_bonus #(
    parameter int unsigned MAX_SITES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_min_gap_we,
    input  ssmb_pkg::t_loc        i_min_gap,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ssmb_pkg::t_loc        i_location,
    input  ssmb_pkg::t_bonus      i_bonus,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ssmb_pkg::t_best       o_best_total,
    output ssmb_pkg::t_idx        o_site_index,
    output ssmb_pkg::t_idx        o_predecessor,
    output logic                  o_overflow,
    output logic                  o_last_out
);

    localparam int unsigned AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int unsigned CW = $clog2(MAX_SITES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SITES);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    ssmb_pkg::t_state r_state, n_state;

    ssmb_pkg::t_loc   r_gap;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_pred, n_pred;
    ssmb_pkg::t_best  r_pred_best, n_pred_best;
    ssmb_pkg::t_best  r_prev_best, n_prev_best;
    ssmb_pkg::t_best  r_best, n_best;
    ssmb_pkg::t_loc   r_loc, n_loc;
    ssmb_pkg::t_bonus r_bonus, n_bonus;
    logic             r_last, n_last;
    logic             r_ovf, n_ovf;

    logic             r_out_valid, n_out_valid;
    ssmb_pkg::t_best  r_out_best, n_out_best;
    ssmb_pkg::t_idx   r_out_index, n_out_index;
    ssmb_pkg::t_idx   r_out_pred, n_out_pred;
    logic             r_out_ovf, n_out_ovf;
    logic             r_out_last, n_out_last;

    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    ssmb_pkg::t_loc   mem_rloc;
    ssmb_pkg::t_best  mem_rbest;

    logic             in_accept;
    logic             out_free;
    logic             hit;
    logic [CW-1:0]    idx_dec;
    logic [CW-1:0]    count_inc;
    ssmb_pkg::t_best  prev_eff;
    logic [ssmb_pkg::BEST_W:0] sum_full;
    ssmb_pkg::t_best  sum_sat;

    ssmb_store #(
        .DEPTH (MAX_SITES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wloc  (r_loc),
        .i_wbest (r_best),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rloc  (mem_rloc),
        .o_rbest (mem_rbest)
    );

    assign in_accept = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign idx_dec   = r_idx - CNT_ONE;
    assign count_inc = r_count + CNT_ONE;
    assign mem_raddr = idx_dec[AW-1:0];
    assign hit       = ({1'b0, mem_rloc} + {1'b0, r_gap}) < {1'b0, r_loc};
    assign prev_eff  = (r_count == '0) ? '0 : r_prev_best;
    assign sum_full  = {{(ssmb_pkg::BEST_W - ssmb_pkg::BONUS_W + 1){1'b0}}, r_bonus}
                     + {1'b0, r_pred_best};
    assign sum_sat   = sum_full[ssmb_pkg::BEST_W] ? ssmb_pkg::BEST_MAX
                                                  : sum_full[ssmb_pkg::BEST_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pred      = r_pred;
        n_pred_best = r_pred_best;
        n_prev_best = r_prev_best;
        n_best      = r_best;
        n_loc       = r_loc;
        n_bonus     = r_bonus;
        n_last      = r_last;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_ready;
        n_out_best  = r_out_best;
        n_out_index = r_out_index;
        n_out_pred  = r_out_pred;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        o_ready     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        unique case (r_state)
            ssmb_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (in_accept) begin
                    n_loc       = i_location;
                    n_bonus     = i_bonus;
                    n_last      = i_last;
                    n_idx       = r_count;
                    n_pred      = '0;
                    n_pred_best = '0;
                    n_ovf       = (r_count >= CNT_MAX);
                    if (r_count >= CNT_MAX) begin
                        n_best  = prev_eff;
                        n_state = ssmb_pkg::S_DONE;
                    end else if (r_count == '0) begin
                        n_state = ssmb_pkg::S_ADD;
                    end else begin
                        n_state = ssmb_pkg::S_READ;
                    end
                end
            end
            ssmb_pkg::S_READ: begin
                mem_re  = 1'b1;
                n_state = ssmb_pkg::S_CMP;
            end
            ssmb_pkg::S_CMP: begin
                if (hit) begin
                    n_pred      = r_idx;
                    n_pred_best = mem_rbest;
                    n_state     = ssmb_pkg::S_ADD;
                end else begin
                    n_idx = idx_dec;
                    if (r_idx == CNT_ONE) begin
                        n_state = ssmb_pkg::S_ADD;
                    end else begin
                        n_state = ssmb_pkg::S_READ;
                    end
                end
            end
            ssmb_pkg::S_ADD: begin
                n_best  = (prev_eff > sum_sat) ? prev_eff : sum_sat;
                n_state = ssmb_pkg::S_DONE;
            end
            ssmb_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_best  = r_best;
                    n_out_ovf   = r_ovf;
                    n_out_last  = r_last;
                    if (r_ovf) begin
                        n_out_index = '0;
                        n_out_pred  = '0;
                    end else begin
                        mem_we      = 1'b1;
                        n_out_index = ssmb_pkg::t_idx'(count_inc);
                        n_out_pred  = ssmb_pkg::t_idx'(r_pred);
                        n_prev_best = r_best;
                        n_count     = count_inc;
                    end
                    if (r_last) begin
                        n_count = '0;
                    end
                    n_state = ssmb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssmb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssmb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap       <= ssmb_pkg::GAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_min_gap_we) begin
                r_gap <= i_min_gap;
            end
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pred      <= n_pred;
        r_pred_best <= n_pred_best;
        r_prev_best <= n_prev_best;
        r_best      <= n_best;
        r_loc       <= n_loc;
        r_bonus     <= n_bonus;
        r_last      <= n_last;
        r_ovf       <= n_ovf;
        r_out_best  <= n_out_best;
        r_out_index <= n_out_index;
        r_out_pred  <= n_out_pred;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_best_total  = r_out_best;
    assign o_site_index  = r_out_index;
    assign o_predecessor = r_out_pred;
    assign o_overflow    = r_out_ovf;
    assign o_last_out    = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("site count beyond capacity");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssmb_pkg::S_READ || r_state == ssmb_pkg::S_CMP) |->
        (r_idx != '0 && r_idx <= r_count))
        else $error("scan index outside stored sites");

    a_ovf_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_site_index == '0 && o_predecessor == '0))
        else $error("overflow result carries an index");

    a_pred_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overflow && MAX_SITES < 2048) |->
        (o_predecessor < o_site_index))
        else $error("predecessor not earlier than site");

    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (o_valid && !o_overflow))
        else $error("store write without a stored-site result");

endmodule

// ===== test/spaced_site_max_bonus_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// spaced_site_max_bonus_tb
// Sites go in through a valid/ready channel. Each accepted transaction is
// scored by a local copy of the spacing rule: latest compatible earlier site,
// best total, capacity overflow and clearing at the end of a run. Every
// returned result is compared field by field against the oldest pending
// score. Runs cover min_gap extremes, a full store with overflow, a long
// output hold-off, and random runs under several idle and stall mixes.
// ============================================================================
module spaced_site_max_bonus_tb;

    localparam int SITE_CAP    = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam ssmb_pkg::t_bonus BONUS_TOP = 16'hFFFF;
    localparam ssmb_pkg::t_loc   LOC_TOP   = 16'hFFFF;

    typedef struct {
        ssmb_pkg::t_best best_total;
        ssmb_pkg::t_idx  site_index;
        ssmb_pkg::t_idx  predecessor;
        logic            overflow;
        logic            last_out;
    } t_site_total;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_min_gap_we = 1'b0;
    ssmb_pkg::t_loc   i_min_gap = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    ssmb_pkg::t_loc   i_location = '0;
    ssmb_pkg::t_bonus i_bonus = '0;
    logic             i_last = 1'b0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    ssmb_pkg::t_best  o_best_total;
    ssmb_pkg::t_idx   o_site_index;
    ssmb_pkg::t_idx   o_predecessor;
    logic             o_overflow;
    logic             o_last_out;

    t_site_total due_totals[$];

    ssmb_pkg::t_loc  run_loc [SITE_CAP];
    ssmb_pkg::t_best run_best [SITE_CAP];
    int              run_len = 0;
    ssmb_pkg::t_loc  gap_cfg = ssmb_pkg::GAP_RESET;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int sites_sent = 0;
    int results_seen = 0;
    int overflow_seen = 0;
    int error_count = 0;
    int cycle_count = 0;

    spaced_site_max_bonus #(
        .MAX_SITES(SITE_CAP)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_min_gap_we  (i_min_gap_we),
        .i_min_gap     (i_min_gap),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_location    (i_location),
        .i_bonus       (i_bonus),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_best_total  (o_best_total),
        .o_site_index  (o_site_index),
        .o_predecessor (o_predecessor),
        .o_overflow    (o_overflow),
        .o_last_out    (o_last_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, due_totals.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_site_total compute_site_total(input ssmb_pkg::t_loc loc,
                                                       input ssmb_pkg::t_bonus bonus,
                                                       input logic last);
        t_site_total     r;
        ssmb_pkg::t_best prev_best;
        logic [26:0]     sum;
        int              pred;
        int              i;
        prev_best = (run_len > 0) ? run_best[run_len-1] : '0;
        r.best_total  = prev_best;
        r.site_index  = '0;
        r.predecessor = '0;
        r.overflow    = 1'b0;
        r.last_out    = last;
        if (run_len >= SITE_CAP) begin
            r.overflow = 1'b1;
        end else begin
            pred = 0;
            i = run_len;
            while (i >= 1 && pred == 0) begin
                if ({1'b0, run_loc[i-1]} + {1'b0, gap_cfg} < {1'b0, loc}) begin
                    pred = i;
                end
                i--;
            end
            sum = {11'b0, bonus} + ((pred > 0) ? {1'b0, run_best[pred-1]} : 27'd0);
            if (sum > {1'b0, ssmb_pkg::BEST_MAX}) begin
                sum = {1'b0, ssmb_pkg::BEST_MAX};
            end
            r.best_total = (prev_best > sum[ssmb_pkg::BEST_W-1:0]) ? prev_best
                                                                   : sum[ssmb_pkg::BEST_W-1:0];
            run_loc[run_len]  = loc;
            run_best[run_len] = r.best_total;
            run_len++;
            r.site_index  = run_len[ssmb_pkg::IDX_W-1:0];
            r.predecessor = pred[ssmb_pkg::IDX_W-1:0];
        end
        if (last) begin
            run_len = 0;
        end
        return r;
    endfunction

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_site_total want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_overflow) begin
                overflow_seen++;
            end
            if (due_totals.size() == 0) begin
                note_failure($sformatf("unexpected result best=%0d idx=%0d pred=%0d",
                                       o_best_total, o_site_index, o_predecessor));
            end else begin
                want = due_totals.pop_front();
                if (o_best_total !== want.best_total || o_site_index !== want.site_index ||
                    o_predecessor !== want.predecessor || o_overflow !== want.overflow ||
                    o_last_out !== want.last_out) begin
                    note_failure($sformatf(
                        "exp best=%0d idx=%0d pred=%0d ovf=%0b last=%0b, got %0d %0d %0d %0b %0b",
                        want.best_total, want.site_index, want.predecessor, want.overflow,
                        want.last_out, o_best_total, o_site_index, o_predecessor, o_overflow,
                        o_last_out));
                end
            end
        end
    end

    // hold off the output for a requested stretch, otherwise stall at random
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic send_site(input ssmb_pkg::t_loc loc, input ssmb_pkg::t_bonus bonus,
                             input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_location <= loc;
        i_bonus    <= bonus;
        i_last     <= last;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        due_totals.push_back(compute_site_total(loc, bonus, last));
        sites_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (due_totals.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_gap(input ssmb_pkg::t_loc value);
        drain();
        @(negedge i_clk);
        i_min_gap_we <= 1'b1;
        i_min_gap    <= value;
        @(posedge i_clk);
        gap_cfg = value;
        @(negedge i_clk);
        i_min_gap_we <= 1'b0;
    endtask

    task automatic send_sorted_run(input int len, input int with_last);
        int               n;
        int               span;
        int               pos;
        ssmb_pkg::t_bonus bonus;
        span = 2 * gap_cfg + 2;
        pos = 65535 - len * span;
        pos = (pos > 0) ? $urandom_range(0, pos) : 0;
        for (n = 0; n < len; n++) begin
            case ($urandom_range(7))
                0: bonus = '0;
                1: bonus = BONUS_TOP;
                default: bonus = ssmb_pkg::t_bonus'($urandom);
            endcase
            send_site(ssmb_pkg::t_loc'(pos), bonus, (n == len - 1) && with_last);
            pos = pos + $urandom_range(0, span);
            if (pos > 65535) begin
                pos = 65535;
            end
        end
    endtask

    task automatic test_directed_edges();
        set_idling(0, 0);
        send_site(16'd0, 16'd0, 1'b0);
        send_site(16'd5, BONUS_TOP, 1'b0);
        send_site(16'd6, 16'd100, 1'b0);
        send_site(16'd12, BONUS_TOP, 1'b0);
        send_site(LOC_TOP, 16'd1, 1'b1);
        send_site(LOC_TOP, 16'd7, 1'b0);
        send_site(16'd0, 16'd9, 1'b0);
        send_site(LOC_TOP, BONUS_TOP, 1'b1);
        send_site(16'd1234, 16'd42, 1'b1);
        send_site(16'd300, 16'h8000, 1'b1);
    endtask

    task automatic test_gap_extremes();
        write_gap(16'd0);
        send_site(16'd3, 16'd10, 1'b0);
        send_site(16'd3, 16'd20, 1'b0);
        send_site(16'd4, 16'd30, 1'b0);
        send_site(16'd2, 16'd5, 1'b1);
        write_gap(16'hFFFF);
        send_site(16'd0, 16'd11, 1'b0);
        send_site(LOC_TOP, 16'd22, 1'b0);
        send_site(LOC_TOP, 16'd33, 1'b1);
        write_gap(ssmb_pkg::GAP_RESET);
    endtask

    task automatic test_capacity_overflow();
        int n;
        int pos;
        set_idling(0, 0);
        pos = $urandom_range(0, 200);
        for (n = 0; n < SITE_CAP; n++) begin
            send_site(ssmb_pkg::t_loc'(pos), BONUS_TOP, 1'b0);
            pos = pos + 6 + $urandom_range(0, 50);
        end
        send_site(ssmb_pkg::t_loc'($urandom), ssmb_pkg::t_bonus'($urandom), 1'b0);
        send_site(LOC_TOP, BONUS_TOP, 1'b0);
        send_site(ssmb_pkg::t_loc'($urandom), ssmb_pkg::t_bonus'($urandom), 1'b1);
        send_site(16'd77, 16'd88, 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_request = 400;
        send_sorted_run(24, 1);
        drain();
    endtask

    task automatic test_random_phases();
        int phase;
        int goal;
        int n;
        int len;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin set_idling(0, 0);   write_gap(16'd0); end
                1: begin
                    set_idling(75, 0);
                    write_gap(ssmb_pkg::t_loc'($urandom_range(1, 200)));
                end
                2: begin set_idling(0, 75);  write_gap(ssmb_pkg::GAP_RESET); end
                default: begin
                    set_idling(19, 19);
                    write_gap(ssmb_pkg::t_loc'($urandom_range(1, 2000)));
                end
            endcase
            goal = sites_sent + 95;
            while (sites_sent < goal) begin
                len = $urandom_range(1, 16);
                if ($urandom_range(3) == 0) begin
                    // noise: random sites, last anywhere
                    for (n = 0; n < len; n++) begin
                        send_site(ssmb_pkg::t_loc'($urandom), ssmb_pkg::t_bonus'($urandom),
                                  ($urandom_range(3) == 0));
                    end
                end else begin
                    send_sorted_run(len, ($urandom_range(9) != 0));
                end
            end
        end
        send_site(16'd1, 16'd1, 1'b1);
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_gap_extremes();
        test_capacity_overflow();
        test_backpressure();
        test_random_phases();
        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d sites, checked %0d results (%0d overflow), %0d mismatches",
                 sites_sent, results_seen, overflow_seen, error_count);
        $display("Covered min_gap 0..65535, a full store, a 400-cycle output hold-off");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ssmb_pkg.sv
rtl/core/ssmb_store.sv
rtl/core/spaced_site_max_bonus.sv
test/spaced_site_max_bonus_tb.sv
